@@ design/ugpq_pkg.sv @@
// ============================================================================
// ugpq_pkg
// Shared types and constants for the uniform grid point query core.
// ============================================================================
package ugpq_pkg;

    // Default store depth
    localparam int DEF_MAX_POINTS = 64;

    // Fixed field widths
    localparam int COORD_W  = 32;
    localparam int CELL_W   = 34;   // query cell bounds, full range of centre +/- radius
    localparam int CSIZE_W  = 31;
    localparam int RAD_W    = 31;
    localparam int PI_W     = 6;
    localparam int CP_W     = 7;
    localparam int OP_W     = 2;
    localparam int DIV_STEPS = 33;

    localparam logic [CSIZE_W-1:0] CELL_SIZE_RESET = 31'd65536;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_BOX    = 2'd2;
    localparam logic [OP_W-1:0] OP_CIRCLE = 2'd3;

    // Kind of result to form
    typedef enum logic [2:0] {
        EK_CLEAR,
        EK_INSERT,
        EK_FULL,
        EK_EMPTY,
        EK_MATCH
    } emit_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       clear;
        logic       div_start;
        logic       div_load;
        logic [1:0] div_sel;
        logic       ptr_inc;
        logic       ptr_dec;
        logic       ptr_top;
        logic       pos_step;
        logic       shift_wr;
        logic       new_wr;
        logic       s1_load;
        logic       s2_load;
        logic       s3_eval;
        logic       eptr_inc;
        logic       emit;
        emit_kind_t emit_kind;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            count_zero;
        logic            div_done;
        logic            scan_end;
        logic            pos_eq_ptr;
        logic            pos_at_end;
        logic            nmatch_zero;
        logic            emit_last;
    } sts_t;

endpackage

@@ design/ugpq_ram.sv @@
// ============================================================================
// ugpq_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module ugpq_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/ugpq_div.sv @@
// ============================================================================
// ugpq_div
// Iterative floor divider: signed dividend by positive divisor, one
// quotient bit per cycle, result rounded towards minus infinity.
// ============================================================================
module ugpq_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [ugpq_pkg::CELL_W-1:0]  dividend,
    input  logic [ugpq_pkg::CSIZE_W-1:0]        divisor,
    output logic                                done,
    output logic signed [ugpq_pkg::CELL_W-1:0]  quotient
);
    import ugpq_pkg::*;

    localparam int MAG_W = CELL_W - 1;
    localparam int REM_W = CSIZE_W + 1;

    logic                     run_reg, fix_reg, done_reg;
    logic [5:0]               cnt_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         quo_reg, quo_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic signed [CELL_W-1:0] q_reg;
    logic [CELL_W-1:0]        neg_a;
    logic [REM_W-1:0]         sh;
    logic                     ge;

    assign neg_a = CELL_W'(0) - CELL_W'(dividend);

    // One restoring step
    always_comb
    begin
        sh       = {rem_reg[REM_W-2:0], quo_reg[MAG_W-1]};
        ge       = sh >= {1'b0, divisor};
        rem_next = ge ? sh - {1'b0, divisor} : sh;
        quo_next = {quo_reg[MAG_W-2:0], ge};
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                fix_reg <= 1'b0;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    run_reg <= 1'b0;
                    fix_reg <= 1'b1;
                end
            end
            else if (fix_reg)
            begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[CELL_W-1];
            quo_reg <= dividend[CELL_W-1] ? neg_a[MAG_W-1:0] : dividend[MAG_W-1:0];
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (fix_reg)
        begin
            if (neg_reg)
            begin
                q_reg <= $signed(CELL_W'(0) - {1'b0, quo_reg}
                                 - CELL_W'(rem_reg != '0));
            end
            else
            begin
                q_reg <= $signed({1'b0, quo_reg});
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ design/ugpq_datapath.sv @@
// ============================================================================
// ugpq_datapath
// Operand registers, cell divider, sorted point store, scan pipeline,
// match buffer and result registers.
// ============================================================================
module ugpq_datapath #(
    parameter int MAX_POINTS = ugpq_pkg::DEF_MAX_POINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ugpq_pkg::OP_W-1:0]           opcode,
    input  logic signed [ugpq_pkg::COORD_W-1:0] x_a,
    input  logic signed [ugpq_pkg::COORD_W-1:0] y_a,
    input  logic signed [ugpq_pkg::COORD_W-1:0] x_b,
    input  logic signed [ugpq_pkg::COORD_W-1:0] y_b,
    input  logic [ugpq_pkg::RAD_W-1:0]          radius,
    input  logic                                cell_size_we,
    input  logic [ugpq_pkg::CSIZE_W-1:0]        cell_size_wdata,
    input  ugpq_pkg::cmd_t                      cmd,
    output ugpq_pkg::sts_t                      sts,
    output logic                                result_valid,
    output logic [ugpq_pkg::PI_W-1:0]           point_index,
    output logic                                match_valid,
    output logic [ugpq_pkg::CP_W-1:0]           cell_points,
    output logic                                status,
    output logic                                last
);
    import ugpq_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int EW = 4 * COORD_W + AW;
    localparam int SQ_W = 2 * RAD_W;

    // Configuration and operands
    logic [CSIZE_W-1:0]        cell_size_reg;
    logic [OP_W-1:0]           op_reg;
    logic signed [COORD_W-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [RAD_W-1:0]          r_reg;
    logic [SQ_W-1:0]           r2_reg;

    // Counters
    logic [CW-1:0] count_reg, ptr_reg, pos_reg, cnt_reg, nmatch_reg, eptr_reg;

    // Cell bounds (low bounds also hold the new point's cell on insert)
    logic signed [CELL_W-1:0] c0x_reg, c0y_reg, c1x_reg, c1y_reg;

    // Scan pipeline
    logic             incell_s1_reg, box_s1_reg, incell_s2_reg, box_s2_reg, big_s2_reg;
    logic [AW-1:0]    idx_s1_reg, idx_s2_reg;
    logic [COORD_W:0] ux_s1_reg, uy_s1_reg;
    logic [SQ_W-1:0]  qx_s2_reg, qy_s2_reg;

    // Result registers
    logic            valid_reg, mv_reg, st_reg, last_reg;
    logic [PI_W-1:0] pi_reg;
    logic [CP_W-1:0] cp_reg;
    logic            mv_next, st_next, last_next;
    logic [PI_W-1:0] pi_next;
    logic [CP_W-1:0] cp_next;

    // Divider
    logic                     circ;
    logic signed [CELL_W-1:0] xa34, ya34, xb34, yb34, r34, div_a, div_q;
    logic [CSIZE_W-1:0]       cs_eff;
    logic                     div_done;

    // Store and match buffer
    logic [EW-1:0]             st_rdata, st_wdata, new_entry;
    logic [AW-1:0]             st_waddr, mt_rdata;
    logic                      st_we, mt_we;
    logic [CW-1:0]             ptr_p1;
    logic signed [COORD_W-1:0] ex, ey, ecx, ecy, ncx, ncy;
    logic [AW-1:0]             eidx, nidx;
    logic signed [CELL_W-1:0]  ecx34, ecy34;
    logic signed [COORD_W:0]   dx, dy;
    logic                      incell, boxhit, bef, hit;

    // Divider operand select
    always_comb
    begin
        circ = (op_reg == OP_CIRCLE);
        xa34 = CELL_W'(xa_reg);
        ya34 = CELL_W'(ya_reg);
        xb34 = CELL_W'(xb_reg);
        yb34 = CELL_W'(yb_reg);
        r34  = $signed(CELL_W'(r_reg));
        case (cmd.div_sel)
            2'd0:    div_a = circ ? xa34 - r34 : xa34;
            2'd1:    div_a = circ ? ya34 - r34 : ya34;
            2'd2:    div_a = circ ? xa34 + r34 : xb34;
            default: div_a = circ ? ya34 + r34 : yb34;
        endcase
        cs_eff = (cell_size_reg == '0) ? CSIZE_W'(1) : cell_size_reg;
    end

    ugpq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (cs_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    // Unpack the entry read from the store and compare it
    always_comb
    begin
        ex    = $signed(st_rdata[AW+127:AW+96]);
        ey    = $signed(st_rdata[AW+95:AW+64]);
        ecx   = $signed(st_rdata[AW+63:AW+32]);
        ecy   = $signed(st_rdata[AW+31:AW]);
        eidx  = st_rdata[AW-1:0];
        ecx34 = CELL_W'(ecx);
        ecy34 = CELL_W'(ecy);
        ncx   = $signed(c0x_reg[COORD_W-1:0]);
        ncy   = $signed(c0y_reg[COORD_W-1:0]);
        nidx  = count_reg[AW-1:0];

        incell = (ecx34 >= c0x_reg) && (ecx34 <= c1x_reg)
              && (ecy34 >= c0y_reg) && (ecy34 <= c1y_reg);
        boxhit = (ex >= xa_reg) && (ex <= xb_reg) && (ey >= ya_reg) && (ey <= yb_reg);
        dx     = (COORD_W+1)'(xa_reg) - (COORD_W+1)'(ex);
        dy     = (COORD_W+1)'(ya_reg) - (COORD_W+1)'(ey);

        if (ncx != ecx)
            bef = ncx < ecx;
        else if (ncy != ecy)
            bef = ncy < ecy;
        else if (xa_reg != ex)
            bef = xa_reg < ex;
        else if (ya_reg != ey)
            bef = ya_reg < ey;
        else
            bef = nidx < eidx;

        hit = incell_s2_reg && (circ
            ? (!big_s2_reg && (qx_s2_reg < r2_reg) && (qy_s2_reg < r2_reg)
               && ((SQ_W+1)'(qx_s2_reg) + (SQ_W+1)'(qy_s2_reg) < (SQ_W+1)'(r2_reg)))
            : box_s2_reg);
    end

    // Store write port: shift up one place, or place the new point
    always_comb
    begin
        ptr_p1    = ptr_reg + CW'(1);
        new_entry = {xa_reg, ya_reg, c0x_reg[COORD_W-1:0], c0y_reg[COORD_W-1:0], nidx};
        st_we     = cmd.shift_wr || cmd.new_wr;
        st_waddr  = cmd.shift_wr ? ptr_p1[AW-1:0] : pos_reg[AW-1:0];
        st_wdata  = cmd.shift_wr ? st_rdata : new_entry;
        mt_we     = cmd.s3_eval && hit;
    end

    ugpq_ram #(.W(EW), .D(MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (st_rdata)
    );

    ugpq_ram #(.W(AW), .D(MAX_POINTS)) u_match (
        .clk   (clk),
        .we    (mt_we),
        .waddr (nmatch_reg[AW-1:0]),
        .wdata (idx_s2_reg),
        .raddr (eptr_reg[AW-1:0]),
        .rdata (mt_rdata)
    );

    // Form the next result fields from the kind of result
    always_comb
    begin
        pi_next   = '0;
        mv_next   = 1'b0;
        cp_next   = '0;
        st_next   = 1'b0;
        last_next = 1'b1;
        case (cmd.emit_kind)
            EK_CLEAR:  ;
            EK_INSERT: pi_next = PI_W'(count_reg);
            EK_FULL:   st_next = 1'b1;
            EK_EMPTY:  cp_next = CP_W'(cnt_reg);
            EK_MATCH:
            begin
                pi_next   = PI_W'(mt_rdata);
                mv_next   = 1'b1;
                cp_next   = CP_W'(cnt_reg);
                last_next = (eptr_reg == nmatch_reg);
            end
            default:   ;
        endcase
    end

    // Control registers: configuration, counters, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= CELL_SIZE_RESET;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            nmatch_reg    <= '0;
            eptr_reg      <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cell_size_we)
                cell_size_reg <= cell_size_wdata;
            valid_reg <= cmd.emit;

            if (cmd.latch)
            begin
                ptr_reg    <= '0;
                pos_reg    <= '0;
                cnt_reg    <= '0;
                nmatch_reg <= '0;
                eptr_reg   <= '0;
            end
            if (cmd.clear)
                count_reg <= '0;
            if (cmd.new_wr)
                count_reg <= count_reg + CW'(1);
            if (cmd.ptr_inc)
                ptr_reg <= ptr_p1;
            if (cmd.ptr_dec)
                ptr_reg <= ptr_reg - CW'(1);
            if (cmd.ptr_top)
                ptr_reg <= count_reg - CW'(1);
            if (cmd.pos_step && !bef)
                pos_reg <= pos_reg + CW'(1);
            if (cmd.s3_eval && incell_s2_reg)
                cnt_reg <= cnt_reg + CW'(1);
            if (mt_we)
                nmatch_reg <= nmatch_reg + CW'(1);
            if (cmd.eptr_inc)
                eptr_reg <= eptr_reg + CW'(1);
        end
    end

    // Payload registers: operands, cell bounds, scan stages, result fields
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= opcode;
            xa_reg <= x_a;
            ya_reg <= y_a;
            xb_reg <= x_b;
            yb_reg <= y_b;
            r_reg  <= radius;
        end
        r2_reg <= r_reg * r_reg;

        if (cmd.div_load && div_done)
        begin
            case (cmd.div_sel)
                2'd0:    c0x_reg <= div_q;
                2'd1:    c0y_reg <= div_q;
                2'd2:    c1x_reg <= div_q;
                default: c1y_reg <= div_q;
            endcase
        end

        if (cmd.s1_load)
        begin
            incell_s1_reg <= incell;
            box_s1_reg    <= boxhit;
            idx_s1_reg    <= eidx;
            ux_s1_reg     <= dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
            uy_s1_reg     <= dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
        end
        if (cmd.s2_load)
        begin
            incell_s2_reg <= incell_s1_reg;
            box_s2_reg    <= box_s1_reg;
            idx_s2_reg    <= idx_s1_reg;
            big_s2_reg    <= (ux_s1_reg[COORD_W:RAD_W] != '0)
                          || (uy_s1_reg[COORD_W:RAD_W] != '0);
            qx_s2_reg     <= ux_s1_reg[RAD_W-1:0] * ux_s1_reg[RAD_W-1:0];
            qy_s2_reg     <= uy_s1_reg[RAD_W-1:0] * uy_s1_reg[RAD_W-1:0];
        end

        if (cmd.emit)
        begin
            pi_reg   <= pi_next;
            mv_reg   <= mv_next;
            cp_reg   <= cp_next;
            st_reg   <= st_next;
            last_reg <= last_next;
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.op          = op_reg;
        sts.full        = (count_reg == CW'(MAX_POINTS));
        sts.count_zero  = (count_reg == '0);
        sts.div_done    = div_done;
        sts.scan_end    = (ptr_reg == count_reg - CW'(1));
        sts.pos_eq_ptr  = (ptr_reg == pos_reg);
        sts.pos_at_end  = (pos_reg == count_reg);
        sts.nmatch_zero = (nmatch_reg == '0);
        sts.emit_last   = (eptr_reg == nmatch_reg);
    end

    assign result_valid = valid_reg;
    assign point_index  = pi_reg;
    assign match_valid  = mv_reg;
    assign cell_points  = cp_reg;
    assign status       = st_reg;
    assign last         = last_reg;

endmodule

@@ design/ugpq_ctrl.sv @@
// ============================================================================
// ugpq_ctrl
// Sequencer: dispatches each item, runs the cell divisions, the sorted
// insert and the two-phase query, and orders result emission.
// ============================================================================
module ugpq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ugpq_pkg::sts_t sts,
    output ugpq_pkg::cmd_t cmd,
    output logic           busy
);
    import ugpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV_GO,
        S_DIV_WAIT,
        S_POS_RD,
        S_POS_CMP,
        S_POS_END,
        S_SH_RD,
        S_SH_WR,
        S_NEW,
        S_SC_RD,
        S_SC_S1,
        S_SC_S2,
        S_SC_S3,
        S_EM_CHK,
        S_EM_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       is_insert;

    assign is_insert = (sts.op == OP_INSERT);

    // Decode commands and next state
    always_comb
    begin
        cmd           = '0;
        cmd.emit_kind = EK_CLEAR;
        cmd.div_sel   = sel_reg;
        state_next    = state_reg;
        sel_next      = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    sel_next   = 2'd0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.op)
                    OP_CLEAR:
                    begin
                        cmd.clear     = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EK_CLEAR;
                        state_next    = S_IDLE;
                    end
                    OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = EK_FULL;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DIV_GO;
                        end
                    end
                    default: state_next = S_DIV_GO;
                endcase
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                cmd.div_load = 1'b1;
                if (sts.div_done)
                begin
                    sel_next = sel_reg + 2'd1;
                    if (is_insert && sel_reg == 2'd1)
                        state_next = sts.count_zero ? S_NEW : S_POS_RD;
                    else if (!is_insert && sel_reg == 2'd3)
                        state_next = sts.count_zero ? S_EM_CHK : S_SC_RD;
                    else
                        state_next = S_DIV_GO;
                end
            end
            // Find the insert position: count entries the new point follows
            S_POS_RD: state_next = S_POS_CMP;
            S_POS_CMP:
            begin
                cmd.pos_step = 1'b1;
                if (sts.scan_end)
                    state_next = S_POS_END;
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_POS_RD;
                end
            end
            S_POS_END:
            begin
                if (sts.pos_at_end)
                    state_next = S_NEW;
                else
                begin
                    cmd.ptr_top = 1'b1;
                    state_next  = S_SH_RD;
                end
            end
            // Shift the tail up one place, top entry first
            S_SH_RD: state_next = S_SH_WR;
            S_SH_WR:
            begin
                cmd.shift_wr = 1'b1;
                if (sts.pos_eq_ptr)
                    state_next = S_NEW;
                else
                begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_SH_RD;
                end
            end
            S_NEW:
            begin
                cmd.new_wr    = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_kind = EK_INSERT;
                state_next    = S_IDLE;
            end
            // Query scan: read, compare, square, decide
            S_SC_RD: state_next = S_SC_S1;
            S_SC_S1:
            begin
                cmd.s1_load = 1'b1;
                state_next  = S_SC_S2;
            end
            S_SC_S2:
            begin
                cmd.s2_load = 1'b1;
                state_next  = S_SC_S3;
            end
            S_SC_S3:
            begin
                cmd.s3_eval = 1'b1;
                if (sts.scan_end)
                    state_next = S_EM_CHK;
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_SC_RD;
                end
            end
            S_EM_CHK:
            begin
                if (sts.nmatch_zero)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EK_EMPTY;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.eptr_inc = 1'b1;
                    state_next   = S_EM_OUT;
                end
            end
            S_EM_OUT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = EK_MATCH;
                cmd.eptr_inc  = 1'b1;
                if (sts.emit_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and divide select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ design/uniform_grid_point_query_core.sv @@
// ============================================================================
// uniform_grid_point_query_core
// Two-dimensional point store on a uniform grid with box and circle queries.
// ============================================================================
// An item is taken when start is high and busy is low; results appear one
// per strobe on result_valid and cannot be held off by the receiver. Cell
// numbers come from an iterative divider. Clear and a refused insert need
// no division. An insert runs two divisions, then a position scan and a
// shift of the tail one entry at a time, since the store RAM has one read
// and one write port (an empty store skips both). A query runs four
// divisions, a scan of each stored entry through the compare and squaring
// stages, then streams the matches at one per cycle from the match buffer.
// ============================================================================
module uniform_grid_point_query_core #(
    parameter int MAX_POINTS = ugpq_pkg::DEF_MAX_POINTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ugpq_pkg::OP_W-1:0]           opcode,
    input  logic signed [ugpq_pkg::COORD_W-1:0] x_a,
    input  logic signed [ugpq_pkg::COORD_W-1:0] y_a,
    input  logic signed [ugpq_pkg::COORD_W-1:0] x_b,
    input  logic signed [ugpq_pkg::COORD_W-1:0] y_b,
    input  logic [ugpq_pkg::RAD_W-1:0]          radius,
    input  logic                                cell_size_we,
    input  logic [ugpq_pkg::CSIZE_W-1:0]        cell_size_wdata,
    output logic                                result_valid,
    output logic [ugpq_pkg::PI_W-1:0]           point_index,
    output logic                                match_valid,
    output logic [ugpq_pkg::CP_W-1:0]           cell_points,
    output logic                                status,
    output logic                                last
);
    import ugpq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ugpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    ugpq_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .opcode          (opcode),
        .x_a             (x_a),
        .y_a             (y_a),
        .x_b             (x_b),
        .y_b             (y_b),
        .radius          (radius),
        .cell_size_we    (cell_size_we),
        .cell_size_wdata (cell_size_wdata),
        .cmd             (cmd),
        .sts             (sts),
        .result_valid    (result_valid),
        .point_index     (point_index),
        .match_valid     (match_valid),
        .cell_points     (cell_points),
        .status          (status),
        .last            (last)
    );

endmodule
